// ----- rtl/gf2inv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2inv_pkg
// Shared constants and helpers for the GF(2^m) inverse pipeline.
// ----------------------------------------------------------------------------
package gf2inv_pkg;

    // Default field degree
    localparam int FIELD_DEGREE_DEF = 10;

    // Reset modulus x^m + x^3 + 1, returned wide; callers truncate to m+1 bits
    function automatic logic [32:0] mod_reset(input int unsigned deg_m);
        logic [32:0] val;
        begin
            val = 33'd1;
            val[deg_m] = 1'b1;
            if (deg_m > 3)
            begin
                val[3] = 1'b1;
            end
            return val;
        end
    endfunction

endpackage

// ----- rtl/gf2_10_inverse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_10_inverse
// Pipelined extended Euclid inverter over GF(2)[x] against a writable modulus.
// ----------------------------------------------------------------------------
// Each word on the input side is inverted modulo the polynomial held in the
// modulus register; the result carries has_inverse set when the gcd is one
// and the coefficient is nonzero. The Euclid loop is laid out as
// 2*FIELD_DEGREE register stages (20 for the default degree), each doing one
// aligned subtract of the remainders and the matching Bezout update, plus a
// load stage and an output register. A new word may enter every cycle unless
// a held result is stalled; it then passes through the load, Euclid and
// output registers in turn. A stall on the output while a result is held
// freezes the whole pipeline and is reflected on in_stall in the same cycle.
// The modulus is sampled as a word enters, so write it only when idle.
// ----------------------------------------------------------------------------
module gf2_10_inverse #(
    parameter int FIELD_DEGREE = gf2inv_pkg::FIELD_DEGREE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [FIELD_DEGREE:0]   cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [FIELD_DEGREE-1:0] operand,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [FIELD_DEGREE-1:0] inverse,
    output logic                    has_inverse
);
    import gf2inv_pkg::*;

    localparam int W     = FIELD_DEGREE + 1;
    localparam int DW    = $clog2(W);
    localparam int NSTEP = 2 * FIELD_DEGREE;
    localparam logic [32:0] MOD_RST_WIDE = mod_reset(FIELD_DEGREE);

    // Degree of a nonzero polynomial (zero maps to 0; callers check for zero)
    function automatic logic [DW-1:0] deg_of(input logic [W-1:0] p);
        logic [DW-1:0] d;
        begin
            d = '0;
            for (int i = 0; i < W; i++)
            begin
                if (p[i])
                begin
                    d = DW'(i);
                end
            end
            return d;
        end
    endfunction

    logic [W-1:0] modulus_reg;
    logic         adv;

    logic         valid_reg [0:NSTEP];
    logic [W-1:0] r0_reg    [0:NSTEP];
    logic [W-1:0] r1_reg    [0:NSTEP];
    logic [W-1:0] s0_reg    [0:NSTEP];
    logic [W-1:0] s1_reg    [0:NSTEP];

    logic                    out_valid_reg;
    logic [FIELD_DEGREE-1:0] inverse_reg;
    logic                    has_inverse_reg;

    // Modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RST_WIDE[W-1:0];
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    // Advance the whole pipeline unless a finished word is held at the output
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Load stage: r0 = modulus, r1 = operand, s0 = 0, s1 = 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg[0] <= modulus_reg;
            r1_reg[0] <= {1'b0, operand};
            s0_reg[0] <= '0;
            s1_reg[0] <= W'(1);
        end
    end

    // Euclid stages: swap when r0 is lower, then cancel the leading term of r0
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic          nz0, nz1, swap;
        logic [DW-1:0] d0, d1, da, db, sh;
        logic [W-1:0]  a, b, sa, sb;
        logic [W-1:0]  r0_next, s0_next;

        always_comb
        begin
            nz0  = |r0_reg[k];
            nz1  = |r1_reg[k];
            d0   = deg_of(r0_reg[k]);
            d1   = deg_of(r1_reg[k]);
            swap = nz1 && (!nz0 || (d0 < d1));
            a    = swap ? r1_reg[k] : r0_reg[k];
            b    = swap ? r0_reg[k] : r1_reg[k];
            sa   = swap ? s1_reg[k] : s0_reg[k];
            sb   = swap ? s0_reg[k] : s1_reg[k];
            da   = swap ? d1 : d0;
            db   = swap ? d0 : d1;
            sh   = da - db;
            r0_next = a;
            s0_next = sa;
            if (|b)
            begin
                r0_next = a ^ (b << sh);
                s0_next = sa ^ (sb << sh);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r0_reg[k+1] <= r0_next;
                r1_reg[k+1] <= b;
                s0_reg[k+1] <= s0_next;
                s1_reg[k+1] <= sb;
            end
        end
    end

    // Pick the gcd and its coefficient from whichever side is nonzero
    logic [W-1:0]            gcd_sel, coef_sel;
    logic                    ok_next;
    logic [FIELD_DEGREE-1:0] inverse_next;

    always_comb
    begin
        gcd_sel      = (|r1_reg[NSTEP]) ? r1_reg[NSTEP] : r0_reg[NSTEP];
        coef_sel     = (|r1_reg[NSTEP]) ? s1_reg[NSTEP] : s0_reg[NSTEP];
        ok_next      = (gcd_sel == W'(1)) && (|coef_sel[FIELD_DEGREE-1:0]);
        inverse_next = ok_next ? coef_sel[FIELD_DEGREE-1:0] : '0;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inverse_reg     <= inverse_next;
            has_inverse_reg <= ok_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign inverse     = inverse_reg;
    assign has_inverse = has_inverse_reg;

    // Checks
    a_no_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_inverse_reg) |-> (inverse_reg == '0))
        else $error("inverse nonzero without has_inverse");

    a_euclid_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NSTEP] |-> ((r0_reg[NSTEP] == '0) || (r1_reg[NSTEP] == '0)))
        else $error("Euclid not finished at last stage");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted word lost at load stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !valid_reg[NSTEP]) |=> !out_valid_reg)
        else $error("result repeated after hand-off");

endmodule

// ----- tb/sv/gf2_10_inverse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_10_inverse_checker
// Watches both channels of the inverter, predicts each inverse and compares.
// ----------------------------------------------------------------------------
module gf2_10_inverse_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [9:0]  operand,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [9:0]  inverse,
    input  logic        has_inverse,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [9:0] inv;
        logic       ok;
    } inv_word_t;

    logic [10:0] modulus;
    inv_word_t   expected_inverses[$];

    function automatic int poly_degree(input logic [31:0] p);
        int d;
        d = -1;
        for (int i = 0; i < 32; i++)
        begin
            if (p[i])
            begin
                d = i;
            end
        end
        return d;
    endfunction

    // Extended Euclid over GF(2)[x]; coefficients kept wide to avoid loss
    function automatic inv_word_t invert_element(input logic [9:0] a, input logic [10:0] m);
        logic [31:0] r0, r1, rem, quo;
        logic [63:0] s0, s1, s2;
        int          dd, dr;
        inv_word_t   w;
        w = '0;
        r0 = {21'd0, m};
        r1 = {22'd0, a};
        s0 = 64'd0;
        s1 = 64'd1;
        if (a != 10'd0)
        begin
            while (r1 != 32'd0)
            begin
                quo = 32'd0;
                rem = r0;
                dd = poly_degree(r1);
                dr = poly_degree(rem);
                while (dr >= dd)
                begin
                    quo[dr - dd] = 1'b1;
                    rem = rem ^ (r1 << (dr - dd));
                    dr = poly_degree(rem);
                end
                s2 = s0;
                for (int i = 0; i < 32; i++)
                begin
                    if (quo[i])
                    begin
                        s2 = s2 ^ (s1 << i);
                    end
                end
                r0 = r1;
                r1 = rem;
                s0 = s1;
                s1 = s2;
            end
            if (r0 == 32'd1 && s0[9:0] != 10'd0)
            begin
                w.inv = s0[9:0];
                w.ok = 1'b1;
            end
        end
        return w;
    endfunction

    assign pending = expected_inverses.size();

    // Track the modulus, queue predictions, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        inv_word_t exp_w;
        if (!rst_n)
        begin
            modulus <= 11'd1033;
            fail_count <= 0;
            expected_inverses.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                modulus <= cfg_wdata;
            end
            if (in_valid && !in_stall)
            begin
                expected_inverses.push_back(invert_element(operand, modulus));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_inverses.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected word: inverse %h flag %b", inverse, has_inverse);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = expected_inverses.pop_front();
                    if (exp_w.inv !== inverse || exp_w.ok !== has_inverse)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch: exp inverse %h flag %b, got %h flag %b",
                                     exp_w.inv, exp_w.ok, inverse, has_inverse);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed stimulus for the GF(2^10) inverter.
// ----------------------------------------------------------------------------
// Sends operands under several moduli, including reducible and low-degree
// ones, with random gaps and output stalls; the checker predicts each word.
// ----------------------------------------------------------------------------
module tb_top;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [9:0]  operand = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [9:0]  inverse;
    logic        has_inverse;
    int          fail_count;
    int          pending;
    bit          long_hold = 1'b0;

    always #6 clk = ~clk;

    gf2_10_inverse dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .operand(operand),
        .out_valid(out_valid), .out_stall(out_stall),
        .inverse(inverse), .has_inverse(has_inverse)
    );

    gf2_10_inverse_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .operand(operand),
        .out_valid(out_valid), .out_stall(out_stall),
        .inverse(inverse), .has_inverse(has_inverse),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Offer one word and hold it until taken; valid stays up for the next word
    task automatic send_operand(input logic [9:0] a, input bit no_gap);
        int g;
        g = no_gap ? 0 : gap_length();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        operand <= a;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid, wait for the pipeline to empty, then write the modulus
    task automatic load_modulus(input logic [10:0] m);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver stalls: random gaps, one long hold on request
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (120) @(posedge clk);
                long_hold = 1'b0;
            end
            g = gap_length();
            out_stall <= (g != 0);
            repeat (g == 0 ? $urandom_range(1, 8) : g) @(posedge clk);
        end
    end

    initial
    begin
        logic [10:0] moduli[8];
        logic [9:0]  a;
        moduli = '{11'h409, 11'h7FF, 11'h400, 11'h001, 11'h00B, 11'h409, 11'h40F, 11'h409};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes under the reset modulus and a few others
        send_operand(10'd0, 1'b0);
        send_operand(10'd1, 1'b0);
        send_operand(10'h3FF, 1'b0);
        send_operand(10'h200, 1'b0);
        send_operand(10'h155, 1'b0);
        send_operand(10'h2AA, 1'b0);
        load_modulus(11'h001);
        send_operand(10'd1, 1'b0);
        send_operand(10'd5, 1'b0);
        load_modulus(11'h00B);
        send_operand(10'h3FF, 1'b0);
        send_operand(10'd2, 1'b0);
        load_modulus(11'h7FF);
        send_operand(10'd3, 1'b0);
        send_operand(10'h3FF, 1'b0);
        load_modulus(11'h409);

        // Back-pressure: long receiver hold while the sender keeps going
        long_hold = 1'b1;
        for (int i = 0; i < 60; i++)
        begin
            send_operand(10'($urandom), 1'b1);
        end

        // Random phases across moduli, including random ones
        for (int p = 0; p < 10; p++)
        begin
            load_modulus(p < 8 ? moduli[p] : 11'($urandom));
            for (int i = 0; i < 105; i++)
            begin
                a = 10'($urandom);
                if ($urandom_range(0, 15) == 0)
                begin
                    a = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'h3FF;
                end
                send_operand(a, 1'b0);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gf2inv_pkg.sv
rtl/gf2_10_inverse.sv
tb/sv/gf2_10_inverse_checker.sv
tb/sv/tb_top.sv
